// ===== src/s2dec_pkg.sv =====
// Shared types, constants and the digit split function for the decimal text converter.
package s2dec_pkg;

   localparam int unsigned VALUE_WIDTH = 16;
   localparam int unsigned CHAR_WIDTH  = 8;
   localparam int unsigned MAX_CHARS   = 6;
   localparam int unsigned COUNT_WIDTH = $clog2(MAX_CHARS + 1);

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;

   localparam logic [15:0] WEIGHT_TEN_THOUSAND = 16'd10000;
   localparam logic [15:0] WEIGHT_THOUSAND     = 16'd1000;
   localparam logic [15:0] WEIGHT_HUNDRED      = 16'd100;
   localparam logic [15:0] WEIGHT_TEN          = 16'd10;

   // One decimal digit and what is left of the value below its weight.
   typedef struct packed {
      logic [3:0]  digit;
      logic [15:0] rem;
   } split_type;

   // Sign and the five magnitude digits of one number, most significant first.
   typedef struct packed {
      logic       neg;
      logic [1:0] d4;
      logic [3:0] d3;
      logic [3:0] d2;
      logic [3:0] d1;
      logic [3:0] d0;
   } digits_type;

   // Nine independent compares against multiples of a constant weight; the highest
   // multiple that fits gives the digit. Valid while v is below ten times the weight.
   function automatic split_type digit_split(input logic [15:0] v, input logic [15:0] w);
      split_type   res;
      logic [19:0] prod;
      res.digit = '0;
      res.rem   = v;
      for (int k = 1; k <= 9; k++) begin
         prod = 20'(k) * 20'(w);
         if ({4'b0000, v} >= prod) begin
            res.digit = 4'(k);
            res.rem   = v - prod[15:0];
         end
      end
      return res;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [3:0] d);
      return CHAR_ZERO + {4'b0000, d};
   endfunction

endpackage

// ===== src/signed_int_to_padded_decimal_ascii.sv =====
// Top level: signed 16-bit integer to zero-padded decimal ASCII text.
//
// Input words arrive on req_ (tdata bits 15:0 hold the signed value). Each
// number leaves on rsp_ as a run of ASCII words, most significant character
// first: a minus sign for negative values, then at least four digits with
// leading zeros, five when the magnitude reaches 10000 (-32768 prints fully).
// tlast marks the final character of each run; no terminator follows.
// A run is four to six words long. The output buffer sends one character per
// cycle while rsp_tready is high, and that sets the sustained rate. New
// numbers keep entering the five-stage digit pipeline while a run is still
// being sent, until the pipeline fills.
// When nothing is queued ahead of it, the first character of a number passes
// through the digit pipeline stages and then the output buffer register
// before it is presented on rsp_.
// When the receiver holds rsp_tready low, the current character stays on the
// port unchanged and the pipeline behind it fills and then drops req_tready.
// Synchronous reset empties the pipeline and the output buffer.
module signed_int_to_padded_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] char_code
   output logic        rsp_tlast
);
   import s2dec_pkg::*;

   logic       pipe_valid;
   logic       pipe_ready;
   digits_type pipe_digits;

   s2dec_digit_pipe u_digit_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_value   (signed'(req_tdata)),
      .out_valid  (pipe_valid),
      .out_ready  (pipe_ready),
      .out_digits (pipe_digits)
   );

   s2dec_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pipe_valid),
      .in_ready  (pipe_ready),
      .in_digits (pipe_digits),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== src/s2dec_digit_pipe.sv =====
// Five-stage pipeline: magnitude, then one decimal digit split per stage.
module s2dec_digit_pipe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [15:0]       in_value,
   output logic                     out_valid,
   input  logic                     out_ready,
   output s2dec_pkg::digits_type    out_digits
);
   import s2dec_pkg::*;

   // Stage advance enables, backward from the consumer.
   logic adv1, adv2, adv3, adv4, adv5;

   logic        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;

   logic        s1_neg_ff;
   logic [15:0] s1_mag_ff;
   logic [15:0] s1_mag_in;

   logic        s2_neg_ff;
   logic [1:0]  s2_d4_ff;
   logic [13:0] s2_rem_ff;
   split_type   s2_split;

   logic        s3_neg_ff;
   logic [1:0]  s3_d4_ff;
   logic [3:0]  s3_d3_ff;
   logic [9:0]  s3_rem_ff;
   split_type   s3_split;

   logic        s4_neg_ff;
   logic [1:0]  s4_d4_ff;
   logic [3:0]  s4_d3_ff;
   logic [3:0]  s4_d2_ff;
   logic [6:0]  s4_rem_ff;
   split_type   s4_split;

   digits_type  s5_digits_ff;
   digits_type  s5_digits_in;
   split_type   s5_split;

   assign adv5 = !s5_valid_ff || out_ready;
   assign adv4 = !s4_valid_ff || adv5;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign in_ready   = adv1;
   assign out_valid  = s5_valid_ff;
   assign out_digits = s5_digits_ff;

   // The most negative input negates to 0x8000, which reads correctly as 32768 unsigned.
   assign s1_mag_in = in_value[15] ? 16'(-in_value) : 16'(in_value);

   assign s2_split = digit_split(s1_mag_ff, WEIGHT_TEN_THOUSAND);
   assign s3_split = digit_split({2'b00, s2_rem_ff}, WEIGHT_THOUSAND);
   assign s4_split = digit_split({6'b000000, s3_rem_ff}, WEIGHT_HUNDRED);
   assign s5_split = digit_split({9'b000000000, s4_rem_ff}, WEIGHT_TEN);

   always_comb begin
      s5_digits_in.neg = s4_neg_ff;
      s5_digits_in.d4  = s4_d4_ff;
      s5_digits_in.d3  = s4_d3_ff;
      s5_digits_in.d2  = s4_d2_ff;
      s5_digits_in.d1  = s5_split.digit;
      s5_digits_in.d0  = s5_split.rem[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= in_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
         if (adv5) s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_neg_ff <= in_value[15];
         s1_mag_ff <= s1_mag_in;
      end
      if (adv2) begin
         s2_neg_ff <= s1_neg_ff;
         s2_d4_ff  <= s2_split.digit[1:0];
         s2_rem_ff <= s2_split.rem[13:0];
      end
      if (adv3) begin
         s3_neg_ff <= s2_neg_ff;
         s3_d4_ff  <= s2_d4_ff;
         s3_d3_ff  <= s3_split.digit;
         s3_rem_ff <= s3_split.rem[9:0];
      end
      if (adv4) begin
         s4_neg_ff <= s3_neg_ff;
         s4_d4_ff  <= s3_d4_ff;
         s4_d3_ff  <= s3_d3_ff;
         s4_d2_ff  <= s4_split.digit;
         s4_rem_ff <= s4_split.rem[6:0];
      end
      if (adv5) begin
         s5_digits_ff <= s5_digits_in;
      end
   end

   a_s2_rem_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_rem_ff < 14'd10000)
      else $error("ten-thousands split left a remainder of 10000 or more");

   a_s4_rem_range: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> s4_rem_ff < 7'd100)
      else $error("hundreds split left a remainder of 100 or more");

   a_out_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> (s5_digits_ff.d0 <= 4'd9) && (s5_digits_ff.d1 <= 4'd9)
                      && (s5_digits_ff.d2 <= 4'd9) && (s5_digits_ff.d3 <= 4'd9))
      else $error("output digit outside 0 to 9");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && !out_ready |=> s5_valid_ff && $stable(s5_digits_ff))
      else $error("last stage changed while stalled");

endmodule

// ===== src/s2dec_serializer.sv =====
// Character buffer that turns one digit set into a run of ASCII words.
module s2dec_serializer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  s2dec_pkg::digits_type  in_digits,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_char,
   output logic                   out_last
);
   import s2dec_pkg::*;

   logic [CHAR_WIDTH-1:0]  char_ff [MAX_CHARS];
   logic [CHAR_WIDTH-1:0]  char_in [MAX_CHARS];
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   load;
   logic                   shift;
   logic [CHAR_WIDTH-1:0]  c4, c3, c2, c1, c0;

   assign out_valid = count_ff != '0;
   assign out_last  = count_ff == COUNT_WIDTH'(1);
   assign out_char  = char_ff[0];

   assign shift    = out_valid && out_ready;
   // A new run may load in the same cycle that the last word of the old one leaves.
   assign in_ready = !out_valid || (out_last && out_ready);
   assign load     = in_valid && in_ready;

   assign c4 = digit_char({2'b00, in_digits.d4});
   assign c3 = digit_char(in_digits.d3);
   assign c2 = digit_char(in_digits.d2);
   assign c1 = digit_char(in_digits.d1);
   assign c0 = digit_char(in_digits.d0);

   always_comb begin
      for (int i = 0; i < MAX_CHARS; i++) begin
         char_in[i] = CHAR_ZERO;
      end
      count_in = count_ff;
      if (load) begin
         unique case ({in_digits.neg, in_digits.d4 != 2'b00})
            2'b11: begin
               char_in[0] = CHAR_MINUS;
               char_in[1] = c4;
               char_in[2] = c3;
               char_in[3] = c2;
               char_in[4] = c1;
               char_in[5] = c0;
               count_in   = COUNT_WIDTH'(6);
            end
            2'b10: begin
               char_in[0] = CHAR_MINUS;
               char_in[1] = c3;
               char_in[2] = c2;
               char_in[3] = c1;
               char_in[4] = c0;
               count_in   = COUNT_WIDTH'(5);
            end
            2'b01: begin
               char_in[0] = c4;
               char_in[1] = c3;
               char_in[2] = c2;
               char_in[3] = c1;
               char_in[4] = c0;
               count_in   = COUNT_WIDTH'(5);
            end
            default: begin
               char_in[0] = c3;
               char_in[1] = c2;
               char_in[2] = c1;
               char_in[3] = c0;
               count_in   = COUNT_WIDTH'(4);
            end
         endcase
      end else if (shift) begin
         for (int i = 0; i < MAX_CHARS - 1; i++) begin
            char_in[i] = char_ff[i + 1];
         end
         count_in = count_ff - COUNT_WIDTH'(1);
      end else begin
         for (int i = 0; i < MAX_CHARS; i++) begin
            char_in[i] = char_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_CHARS; i++) begin
         char_ff[i] <= char_in[i];
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(MAX_CHARS))
      else $error("character count above the longest run");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      shift && !out_last |=> out_valid && count_ff == $past(count_ff) - COUNT_WIDTH'(1))
      else $error("run ended or skipped before its last word");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_char == CHAR_MINUS
                    || (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 8'd9))
      else $error("word is neither a minus sign nor a digit");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the signed integer to zero-padded decimal ASCII converter.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import s2dec_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RANDOM_ITEMS = 196;
   localparam int CALM_ITEMS   = 40;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PRINT_CAP    = 50;

   // One character of expected text and the number it came from.
   typedef struct {
      logic [CHAR_WIDTH-1:0]  code;
      logic                   last;
      logic [VALUE_WIDTH-1:0] source;
   } char_word_type;

   class decimal_text_checker;
      char_word_type pending_chars[$];
      int            mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      task report_mismatch(input string msg);
         mismatch_count++;
         if (mismatch_count <= PRINT_CAP) begin
            $display("tb_top: mismatch: %s", msg);
         end
      endtask

      // Expands one accepted number into its characters, most significant first.
      function void add_number(input logic [VALUE_WIDTH-1:0] value);
         logic          neg;
         logic [16:0]   mag;
         logic [3:0]    digit [5];
         int            ndig;
         int            k;
         char_word_type w;
         neg = value[VALUE_WIDTH-1];
         mag = neg ? (17'h10000 - {1'b0, value}) : {1'b0, value};
         for (k = 0; k < 5; k++) begin
            digit[k] = 4'(mag % 17'd10);
            mag = mag / 17'd10;
         end
         // The magnitude never exceeds 32768, so five digits always suffice.
         ndig = (digit[4] != 4'd0) ? 5 : 4;
         w.source = value;
         if (neg) begin
            w.code = CHAR_MINUS;
            w.last = 1'b0;
            pending_chars.push_back(w);
         end
         for (k = ndig - 1; k >= 0; k--) begin
            w.code = CHAR_ZERO + {4'b0000, digit[k]};
            w.last = (k == 0);
            pending_chars.push_back(w);
         end
      endfunction

      task check_char(input logic [CHAR_WIDTH-1:0] code, input logic last);
         char_word_type w;
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected word code=%0d last=%0b", code, last));
         end else begin
            w = pending_chars.pop_front();
            if (code !== w.code) begin
               report_mismatch($sformatf("value %0d: code %0d, expected %0d",
                                         $signed(w.source), code, w.code));
            end
            if (last !== w.last) begin
               report_mismatch($sformatf("value %0d, code %0d: last %0b, expected %0b",
                                         $signed(w.source), code, last, w.last));
            end
         end
      endtask

      function int pending();
         return pending_chars.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] char_code
   logic        rsp_tlast;

   decimal_text_checker book;
   int                  idle_pct = 0;
   int unsigned         cycle_count = 0;

   signed_int_to_padded_decimal_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         book.check_char(rsp_tdata, rsp_tlast);
      end
   end

   // Receiver: ready by default, with random stall bursts while idling is on.
   initial begin
      @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct / 2 + 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one number and returns at the edge where it is accepted.
   task automatic send_number(input logic [15:0] value);
      if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.add_number(value);
   endtask

   function automatic logic [15:0] pick_number();
      int n;
      case ($urandom_range(0, 9))
         0, 1, 2: n = $urandom_range(0, 65535);
         3:       n = $urandom_range(0, 9999);
         4:       n = $urandom_range(0, 99);
         5:       n = -$urandom_range(1, 999);
         6:       n = -$urandom_range(1000, 9999);
         7:       n = -$urandom_range(10000, 32768);
         8:       n = $urandom_range(10000, 32767);
         default: begin
            // Values at the edges where the text length or the leading digit changes, and the ends of the range.
            case ($urandom_range(0, 7))
               0:       n = 9999;
               1:       n = 10000;
               2:       n = -999;
               3:       n = -1000;
               4:       n = -9999;
               5:       n = -10000;
               6:       n = -32768;
               default: n = 32767;
            endcase
         end
      endcase
      return 16'(n);
   endfunction

   initial begin
      int directed [$];
      int i;
      book = new();
      directed = '{0, 5, -42, 9, 10, 99, 100, 999, 1000, 9999, 10000, 12345, 32767,
                   -1, -9, -999, -1000, -9999, -10000, -12345, -32767, -32768,
                   16'h5555, -21846};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[j]) begin
         send_number(16'(directed[j]));
      end

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 30 == 0) begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               2:       idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
            idle_pct = 0;
         end
         send_number(pick_number());
      end
      req_tvalid <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (book.mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
